FILE: sv/psg_pkg.sv
// Shared types, constants and functions of the plasma pixel generator.
package psg_pkg;

	localparam int SINE_ENTRIES_DEF = 1024;
	localparam logic [10:0] MAX_DIM = 11'd1024;
	localparam int DIM_W = 11;
	localparam int PIX_W = 10;
	localparam int VW = 30;
	localparam int SQ_STEPS = 15;
	localparam int LATENCY = SQ_STEPS + 6;
	localparam logic [29:0] INV_TWO_PI = 30'd683565276;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [10:0] WIDTH_RST = 11'd800;
	localparam logic [10:0] HEIGHT_RST = 11'd600;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [VW-1:0] rem;
		logic [VW-1:0] res;
	} sq_lane_t;

	typedef struct packed {
		logic               valid;
		logic signed [17:0] sxy;
		sq_lane_t           c;
		sq_lane_t           o;
	} cell_t;

	function automatic logic [10:0] dim_clamp(logic [10:0] v);
		logic [10:0] r;
		r = (v > MAX_DIM) ? MAX_DIM : v;
		return r;
	endfunction

	// One digit of the square root; bitv is the current power of four.
	function automatic sq_lane_t sqrt_step(sq_lane_t a, logic [VW-1:0] bitv);
		sq_lane_t   r;
		logic [VW:0] trial;
		trial = {1'b0, a.res} + {1'b0, bitv};
		if ({1'b0, a.rem} >= trial) begin
			r.rem = a.rem - trial[VW-1:0];
			r.res = (a.res >> 1) + bitv;
		end else begin
			r.rem = a.rem;
			r.res = a.res >> 1;
		end
		return r;
	endfunction

	// Quarter-wave sine entry, Q16, from a Q30 Taylor series (elaboration only).
	function automatic logic [15:0] sine_entry(int unsigned i, int unsigned lg);
		logic [63:0]        theta;
		logic [63:0]        th2;
		logic [63:0]        term;
		logic signed [63:0] acc;
		logic [63:0]        v;
		theta = (64'(i) * TWO_PI_Q30) >> lg;
		th2 = (theta * theta) >> 30;
		term = theta;
		acc = $signed(theta);
		for (int k = 1; k <= 9; k++) begin
			term = ((term * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) acc = acc - $signed(term);
			else acc = acc + $signed(term);
		end
		if (acc < 0) acc = 0;
		v = (64'(acc) + 64'd8192) >> 14;
		if (v > 64'd65535) v = 64'd65535;
		return v[15:0];
	endfunction

endpackage

FILE: sv/psg_sine.sv
// Quarter-wave sine table lookup: phase in, signed Q16 sine out.
module psg_sine import psg_pkg::*; #(
	parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
	input  logic [$clog2(SINE_ENTRIES)-1:0] phase,
	output logic signed [16:0]              value
);

	localparam int PW = $clog2(SINE_ENTRIES);
	localparam int QW = PW - 2;
	localparam int Q = SINE_ENTRIES / 4;

	typedef logic [15:0] rom_t [Q];

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i < Q; i++) t[i] = sine_entry(i, PW);
		return t;
	endfunction

	localparam rom_t ROM = build_rom();
	localparam logic [15:0] PEAK = sine_entry(Q, PW);

	logic [1:0]    quad;
	logic [QW-1:0] ofs;
	logic [QW-1:0] idx;
	logic [15:0]   mag;

	always_comb begin
		quad = phase[PW-1 -: 2];
		ofs = phase[QW-1:0];
		idx = quad[0] ? (QW'(0) - ofs) : ofs;
		// odd quadrant at zero offset is the peak entry past the table
		mag = (quad[0] && ofs == '0) ? PEAK : ROM[idx];
		value = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

FILE: sv/psg_sqrt_cell.sv
// One square-root digit cell for both distance lanes, with its sideband.
module psg_sqrt_cell import psg_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cell_t cin,
	output cell_t cout
);

	localparam logic [VW-1:0] BITV = VW'(1) << (2 * (SQ_STEPS - 1 - STEP));

	logic               valid_q;
	logic signed [17:0] sxy_q;
	sq_lane_t           c_q;
	sq_lane_t           o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= cin.valid;
	end

	always_ff @(posedge clk) begin
		sxy_q <= cin.sxy;
		c_q <= sqrt_step(cin.c, BITV);
		o_q <= sqrt_step(cin.o, BITV);
	end

	assign cout = '{valid: valid_q, sxy: sxy_q, c: c_q, o: o_q};

endmodule

FILE: sv/plasma_pixel_generator.sv
// Plasma pixel generator top level: four-sine plasma gray level per pixel.
//
// Usage: drive pixel_x/pixel_y with start high; the coordinate is taken at
// any rising edge where start is high and busy is low. One coordinate per
// clock is sustained, throughput is one transaction per cycle.
// The pipeline is the squaring and phase setup stages, fifteen square-root
// digit cells (one digit per cell, both distances side by side), a phase
// multiply, a phase rounding stage and the output register.
// gray_level is valid for exactly one cycle while done is high; the receiver
// cannot stall, so results stream out in input order.
// frame_width/frame_height are written via cfg_we/cfg_index/cfg_wdata, by the user
// only while no transaction is in flight (unenforced); values above 1024 are clamped.
// Reset (arst_n low) clears the pipeline valid bits, sets the frame to
// 800x600 and holds busy high until the first clock after release.
module plasma_pixel_generator import psg_pkg::*; #(
	parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [PIX_W-1:0] pixel_x,
	input  logic [PIX_W-1:0] pixel_y,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata,
	output logic             done,
	output logic [7:0]       gray_level
);

	localparam int PW = $clog2(SINE_ENTRIES);

	logic [DIM_W-1:0] width_q, height_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_FRAME_WIDTH:  width_q <= dim_clamp(cfg_wdata);
					REG_FRAME_HEIGHT: height_q <= dim_clamp(cfg_wdata);
					default: ;
				endcase
			end
		end
	end

	assign busy = busy_q;

	// stage 1: offsets from the centre, doubled to stay integer
	logic               valid_s1;
	logic [PIX_W-1:0]   x_s1, y_s1;
	logic signed [11:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start && !busy_q;
	end

	always_ff @(posedge clk) begin
		x_s1 <= pixel_x;
		y_s1 <= pixel_y;
		dx_s1 <= $signed({1'b0, pixel_x, 1'b0}) - $signed({1'b0, width_q});
		dy_s1 <= $signed({1'b0, pixel_y, 1'b0}) - $signed({1'b0, height_q});
	end

	// stage 2: squares and x/y phase products
	logic               valid_s2;
	logic [21:0]        dxx_s2, dyy_s2;
	logic [19:0]        xx_s2, yy_s2;
	logic [39:0]        px_s2, py_s2;
	logic signed [23:0] dxx_full, dyy_full;

	always_comb begin
		dxx_full = dx_s1 * dx_s1;
		dyy_full = dy_s1 * dy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		dxx_s2 <= dxx_full[21:0];
		dyy_s2 <= dyy_full[21:0];
		xx_s2 <= 20'(x_s1) * 20'(x_s1);
		yy_s2 <= 20'(y_s1) * 20'(y_s1);
		px_s2 <= 40'(x_s1) * 40'(INV_TWO_PI);
		py_s2 <= 40'(y_s1) * 40'(INV_TWO_PI);
	end

	// stage 3: radicands and rounded x/y phases
	logic          valid_s3;
	logic [VW-1:0] vc_s3, v0_s3;
	logic [PW-1:0] phx_s3, phy_s3;
	logic [22:0]   sum_c;
	logic [20:0]   sum_o;
	logic [40:0]   rnd_x, rnd_y;

	always_comb begin
		sum_c = 23'(dxx_s2) + 23'(dyy_s2);
		sum_o = 21'(xx_s2) + 21'(yy_s2);
		rnd_x = 41'(px_s2) + (41'(1) << (35 - PW));
		rnd_y = 41'(py_s2) + (41'(1) << (36 - PW));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		vc_s3 <= {1'b0, sum_c, 6'b0};
		v0_s3 <= {1'b0, sum_o, 8'b0};
		phx_s3 <= rnd_x[36-PW +: PW];
		phy_s3 <= rnd_y[37-PW +: PW];
	end

	logic signed [16:0] sin_x, sin_y;

	psg_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sin_x (.phase(phx_s3), .value(sin_x));
	psg_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sin_y (.phase(phy_s3), .value(sin_y));

	// square-root chain, one digit per cell
	cell_t chain [SQ_STEPS+1];

	assign chain[0] = '{
		valid: valid_s3,
		sxy:   18'(sin_x) + 18'(sin_y),
		c:     '{rem: vc_s3, res: '0},
		o:     '{rem: v0_s3, res: '0}
	};

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_cell
		psg_sqrt_cell #(.STEP(i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cin   (chain[i]),
			.cout  (chain[i+1])
		);
	end

	// stage 19: distance phase products
	logic               valid_s19;
	logic signed [17:0] sxy_s19;
	logic [44:0]        pc_s19, po_s19;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s19 <= 1'b0;
		else valid_s19 <= chain[SQ_STEPS].valid;
	end

	always_ff @(posedge clk) begin
		sxy_s19 <= chain[SQ_STEPS].sxy;
		pc_s19 <= 45'(chain[SQ_STEPS].c.res[SQ_STEPS-1:0]) * 45'(INV_TWO_PI);
		po_s19 <= 45'(chain[SQ_STEPS].o.res[SQ_STEPS-1:0]) * 45'(INV_TWO_PI);
	end

	// stage 20: rounded distance phases
	logic               valid_s20;
	logic signed [17:0] sxy_s20;
	logic [PW-1:0]      phc_s20, pho_s20;
	logic [45:0]        rnd_c, rnd_o;

	always_comb begin
		rnd_c = 46'(pc_s19) + (46'(1) << (38 - PW));
		rnd_o = 46'(po_s19) + (46'(1) << (38 - PW));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s20 <= 1'b0;
		else valid_s20 <= valid_s19;
	end

	always_ff @(posedge clk) begin
		sxy_s20 <= sxy_s19;
		phc_s20 <= rnd_c[39-PW +: PW];
		pho_s20 <= rnd_o[39-PW +: PW];
	end

	logic signed [16:0] sin_c, sin_o;
	logic signed [19:0] total;
	logic [7:0]         gray_d;

	psg_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sin_c (.phase(phc_s20), .value(sin_c));
	psg_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sin_o (.phase(pho_s20), .value(sin_o));

	// gray = (2^18 + sum of sines) >> 11, never negative
	always_comb begin
		total = 20'sd262144 + 20'(sxy_s20) + 20'(sin_c) + 20'(sin_o);
		gray_d = (total[19:11] > 9'd255) ? 8'd255 : total[18:11];
	end

	logic       done_q;
	logic [7:0] gray_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= valid_s20;
	end

	always_ff @(posedge clk) begin
		gray_q <= gray_d;
	end

	assign done = done_q;
	assign gray_level = gray_q;

endmodule

FILE: sv/psg_checker.sv
// Port-level checker for the plasma pixel generator, bound to the top level.
module psg_checker import psg_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [7:0] gray_level
);

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted transaction produced no result in time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching transaction");

	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose outside reset");

	a_gray_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(gray_level))
		else $error("unknown gray level on a result");

endmodule

bind plasma_pixel_generator psg_checker u_psg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.gray_level(gray_level)
);
